/* src/ubxp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package ubxp_pkg;

   // Framing bytes and message codes.
   localparam logic [7:0] SYNC_FIRST  = 8'hB5;
   localparam logic [7:0] SYNC_SECOND = 8'h62;
   localparam logic [7:0] CLASS_NAV   = 8'h01;
   localparam logic [7:0] ID_PVT      = 8'h07;
   localparam logic [7:0] ID_VELNED   = 8'h12;

   localparam logic [1:0] KIND_PVT    = 2'd1;
   localparam logic [1:0] KIND_VELNED = 2'd2;

   localparam int PvtLen     = 92;
   localparam int AddrWidth  = $clog2(PvtLen);

   // Calendar constants.
   localparam logic [15:0] FIRST_YEAR  = 16'd2025;
   localparam logic [15:0] EPOCH_YEAR  = 16'd1970;
   localparam logic [31:0] SEC_PER_DAY = 32'd86400;
   localparam logic [19:0] SEC_PER_HR  = 20'd3600;
   localparam logic [19:0] SEC_PER_MIN = 20'd60;
   localparam logic [31:0] DAYS_PER_YR = 32'd365;
   // Leap days counted up to and including 1969.
   localparam logic [31:0] LEAPS_EPOCH = 32'd477;
   // ceil(2^24 / 100): exact quotient by 100 for any 16-bit value.
   localparam logic [33:0] RECIP_100   = 34'd167773;

   // Word slots read during a result burst.
   localparam logic [3:0] WORD_DATE  = 4'd14;
   localparam logic [3:0] WORD_CLOCK = 4'd15;
   localparam logic [3:0] FIELD_TIME = 4'd14;
   localparam logic [3:0] FIELD_FIX  = 4'd8;
   localparam logic [3:0] FIELD_NSV  = 4'd9;
   localparam logic [3:0] FIELD_ACC0 = 4'd10;

   typedef enum logic [3:0] {
      PH_HUNT1   = 4'd0,
      PH_HUNT2   = 4'd1,
      PH_CLASS   = 4'd2,
      PH_ID      = 4'd3,
      PH_LENLO   = 4'd4,
      PH_LENHI   = 4'd5,
      PH_PAYLOAD = 4'd6,
      PH_CKA     = 4'd7,
      PH_CKB     = 4'd8,
      PH_SKIP    = 4'd9,
      PH_SKIPCK  = 4'd10
   } parse_phase_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'd0,
      ST_READ  = 3'd1,
      ST_SHIFT = 3'd2,
      ST_CAP   = 3'd3,
      ST_TIME1 = 3'd4,
      ST_TIME2 = 3'd5,
      ST_TIME3 = 3'd6,
      ST_EMIT  = 3'd7
   } ctrl_state_type;

   typedef struct packed {
      logic            byte_en;
      parse_phase_type phase;
      logic            rd_en;
      logic [3:0]      word;
      logic [1:0]      byte_idx;
      logic            cap;
      logic            time1;
      logic            time2;
      logic            time3;
      logic            load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic is_sync1;
      logic is_sync2;
      logic is_class;
      logic is_id_pvt;
      logic is_id_velned;
      logic kind_pvt;
      logic len_ok;
      logic len_zero;
      logic pay_last;
      logic skip_last;
      logic skipck_last;
      logic ckb_ok;
      logic out_free;
   } dp_status_type;

   // Payload offset of each burst word.
   function automatic logic [AddrWidth-1:0] word_offset(input logic [3:0] word);
      logic [AddrWidth-1:0] off;
      case (word)
         4'd0:    off = AddrWidth'(28);
         4'd1:    off = AddrWidth'(24);
         4'd2:    off = AddrWidth'(64);
         4'd3:    off = AddrWidth'(60);
         4'd4:    off = AddrWidth'(36);
         4'd5:    off = AddrWidth'(56);
         4'd6:    off = AddrWidth'(52);
         4'd7:    off = AddrWidth'(48);
         4'd8:    off = AddrWidth'(20);
         4'd9:    off = AddrWidth'(23);
         4'd10:   off = AddrWidth'(72);
         4'd11:   off = AddrWidth'(40);
         4'd12:   off = AddrWidth'(68);
         4'd13:   off = AddrWidth'(44);
         4'd14:   off = AddrWidth'(4);
         default: off = AddrWidth'(8);
      endcase
      return off;
   endfunction

   // Days in the months before the given one; months past December count all twelve.
   function automatic logic [8:0] days_before_month(input logic [7:0] month);
      logic [8:0] d;
      case (month)
         8'd0, 8'd1: d = 9'd0;
         8'd2:       d = 9'd31;
         8'd3:       d = 9'd59;
         8'd4:       d = 9'd90;
         8'd5:       d = 9'd120;
         8'd6:       d = 9'd151;
         8'd7:       d = 9'd181;
         8'd8:       d = 9'd212;
         8'd9:       d = 9'd243;
         8'd10:      d = 9'd273;
         8'd11:      d = 9'd304;
         8'd12:      d = 9'd334;
         default:    d = 9'd365;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

/* src/ubxp_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none

// Byte stream channel.
interface ubxp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

// Decoded field channel.
interface ubxp_rsp_if;
   logic               valid;
   logic               ready;
   logic [3:0]         field_id;
   logic signed [32:0] field_value;
   logic               last;
   modport source (output valid, output field_id, output field_value, output last,
                   input ready);
   modport sink (input valid, input field_id, input field_value, input last,
                 output ready);
endinterface

`default_nettype wire

/* src/ubxp_dp.sv */
`timescale 1ns / 1ps
`default_nettype none

module ubxp_dp (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [7:0]            rx_byte,
   input  wire ubxp_pkg::dp_cmd_type  cmd,
   output ubxp_pkg::dp_status_type    status,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [3:0]                 rsp_field_id,
   output logic signed [32:0]         rsp_field_value,
   output logic                       rsp_last
);
   import ubxp_pkg::*;

   logic [7:0]  sum_a_ff, sum_a_in, sum_b_ff, sum_b_in;
   logic [15:0] cnt_ff, cnt_in, len_ff, len_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  check_a_ff, check_a_in;
   logic [15:0] len_full;
   logic [7:0]  add_a, add_b;

   logic [7:0]           mem [PvtLen];
   logic [7:0]           rd_data_ff;
   logic                 rd_vld_ff;
   logic [AddrWidth-1:0] rd_addr;
   logic [31:0]          word_ff;

   logic [15:0] year_ff;
   logic [7:0]  month_ff, day_ff, hour_ff, min_ff, sec_ff;
   logic [9:0]  q_ym1_ff, q_y_ff;
   logic        late_ff;
   logic [31:0] days_ff, days_in, time_ff;
   logic [19:0] hms_ff;
   logic [15:0] ym1;
   logic [33:0] prod_ym1, prod_y;
   logic [31:0] leaps;
   logic        zero100, leap;
   logic [31:0] cum;

   logic               out_valid_ff;
   logic [3:0]         out_id_ff;
   logic signed [32:0] out_value_ff;
   logic               out_last_ff;
   logic [3:0]         field_id;
   logic signed [32:0] field_value;

   // Header and checksum compares on the incoming byte.
   assign len_full = {rx_byte, len_ff[7:0]};
   assign add_a    = sum_a_ff + rx_byte;
   assign add_b    = sum_b_ff + add_a;

   always_comb begin
      status.is_sync1     = (rx_byte == SYNC_FIRST);
      status.is_sync2     = (rx_byte == SYNC_SECOND);
      status.is_class     = (rx_byte == CLASS_NAV);
      status.is_id_pvt    = (rx_byte == ID_PVT);
      status.is_id_velned = (rx_byte == ID_VELNED);
      status.kind_pvt     = (kind_ff == KIND_PVT);
      status.len_ok       = (len_full == 16'(PvtLen));
      status.len_zero     = (len_full == 16'd0);
      status.pay_last     = (cnt_ff == 16'(PvtLen - 1));
      status.skip_last    = ((cnt_ff + 16'd1) == len_ff);
      status.skipck_last  = ((cnt_ff + 16'd1) >= 16'd2);
      status.ckb_ok       = (check_a_ff == sum_a_ff) && (rx_byte == sum_b_ff);
      status.out_free     = !out_valid_ff || rsp_ready;
   end

   // Per-byte frame bookkeeping.
   always_comb begin
      sum_a_in   = sum_a_ff;
      sum_b_in   = sum_b_ff;
      cnt_in     = cnt_ff;
      len_in     = len_ff;
      kind_in    = kind_ff;
      check_a_in = check_a_ff;
      if (cmd.byte_en) begin
         unique case (cmd.phase)
            PH_HUNT2: begin
               if (status.is_sync2) begin
                  sum_a_in = 8'd0;
                  sum_b_in = 8'd0;
               end
            end
            PH_CLASS: begin
               if (status.is_class) begin
                  sum_a_in = add_a;
                  sum_b_in = add_b;
               end
            end
            PH_ID: begin
               if (status.is_id_pvt || status.is_id_velned) begin
                  kind_in  = status.is_id_pvt ? KIND_PVT : KIND_VELNED;
                  sum_a_in = add_a;
                  sum_b_in = add_b;
               end
            end
            PH_LENLO: begin
               sum_a_in = add_a;
               sum_b_in = add_b;
               len_in   = {8'd0, rx_byte};
            end
            PH_LENHI: begin
               len_in = len_full;
               cnt_in = 16'd0;
               if (status.kind_pvt && status.len_ok) begin
                  sum_a_in = add_a;
                  sum_b_in = add_b;
               end
            end
            PH_PAYLOAD: begin
               sum_a_in = add_a;
               sum_b_in = add_b;
               cnt_in   = cnt_ff + 16'd1;
            end
            PH_CKA: check_a_in = rx_byte;
            PH_SKIP: cnt_in = status.skip_last ? 16'd0 : cnt_ff + 16'd1;
            PH_SKIPCK: cnt_in = cnt_ff + 16'd1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_a_ff   <= 8'd0;
         sum_b_ff   <= 8'd0;
         cnt_ff     <= 16'd0;
         len_ff     <= 16'd0;
         kind_ff    <= 2'd0;
         check_a_ff <= 8'd0;
      end else begin
         sum_a_ff   <= sum_a_in;
         sum_b_ff   <= sum_b_in;
         cnt_ff     <= cnt_in;
         len_ff     <= len_in;
         kind_ff    <= kind_in;
         check_a_ff <= check_a_in;
      end
   end

   // Payload store: written while the payload streams in, read a byte per cycle in bursts.
   assign rd_addr = word_offset(cmd.word) + AddrWidth'(cmd.byte_idx);

   always_ff @(posedge clock) begin
      if (cmd.byte_en && cmd.phase == PH_PAYLOAD) begin
         mem[cnt_ff[AddrWidth-1:0]] <= rx_byte;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.rd_en;
      end
   end

   // Little-endian word assembly, one byte per cycle.
   always_ff @(posedge clock) begin
      if (rd_vld_ff) begin
         word_ff <= {rd_data_ff, word_ff[31:8]};
      end
   end

   // Timestamp unit: capture date and clock, divide year by 100, sum days, scale.
   assign ym1      = year_ff - 16'd1;
   assign prod_ym1 = {18'd0, ym1} * RECIP_100;
   assign prod_y   = {18'd0, year_ff} * RECIP_100;
   assign leaps    = 32'(ym1[15:2]) - 32'(q_ym1_ff) + 32'(q_ym1_ff[9:2]);
   assign zero100  = (17'(q_y_ff) * 17'd100) == {1'b0, year_ff};
   assign leap     = (year_ff[1:0] == 2'b00) && (!zero100 || q_y_ff[1:0] == 2'b00);
   assign cum      = 32'(days_before_month(month_ff))
                   + ((leap && month_ff >= 8'd3) ? 32'd1 : 32'd0);
   assign days_in  = 32'(16'(year_ff - EPOCH_YEAR)) * DAYS_PER_YR + leaps - LEAPS_EPOCH
                   + cum + 32'(day_ff) - 32'd1;

   always_ff @(posedge clock) begin
      if (cmd.cap && cmd.word == WORD_DATE) begin
         year_ff  <= word_ff[15:0];
         month_ff <= word_ff[23:16];
         day_ff   <= word_ff[31:24];
      end
      if (cmd.cap && cmd.word == WORD_CLOCK) begin
         hour_ff <= word_ff[7:0];
         min_ff  <= word_ff[15:8];
         sec_ff  <= word_ff[23:16];
      end
      if (cmd.time1) begin
         q_ym1_ff <= prod_ym1[33:24];
         q_y_ff   <= prod_y[33:24];
         late_ff  <= (year_ff >= FIRST_YEAR);
      end
      if (cmd.time2) begin
         days_ff <= days_in;
         hms_ff  <= 20'(hour_ff) * SEC_PER_HR + 20'(min_ff) * SEC_PER_MIN + 20'(sec_ff);
      end
      if (cmd.time3) begin
         time_ff <= late_ff ? (days_ff * SEC_PER_DAY) + 32'(hms_ff) : 32'd0;
      end
   end

   // Field formatting from the assembled word.
   always_comb begin
      field_id = (cmd.word == WORD_CLOCK) ? FIELD_TIME : cmd.word;
      if (cmd.word == WORD_CLOCK) begin
         field_value = signed'({1'b0, time_ff});
      end else if (field_id == FIELD_FIX || field_id == FIELD_NSV) begin
         field_value = signed'({25'd0, word_ff[7:0]});
      end else if (field_id >= FIELD_ACC0) begin
         field_value = signed'({1'b0, word_ff});
      end else begin
         field_value = signed'({word_ff[31], word_ff});
      end
   end

   // Output register; a new transaction loads as the old one leaves.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_id_ff    <= field_id;
         out_value_ff <= field_value;
         out_last_ff  <= (field_id == FIELD_TIME);
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_field_id    = out_id_ff;
   assign rsp_field_value = out_value_ff;
   assign rsp_last        = out_last_ff;

   // A result is loaded only into a free output register.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!out_valid_ff || rsp_ready))
      else $error("result loaded over a pending transaction");

   // Word assembly follows a read issued in the cycle before.
   assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> $past(cmd.rd_en))
      else $error("read data flagged without a read");

endmodule

`default_nettype wire

/* src/ubxp_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module ubxp_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire ubxp_pkg::dp_status_type status,
   output ubxp_pkg::dp_cmd_type         cmd
);
   import ubxp_pkg::*;

   ctrl_state_type  state_ff, state_in;
   parse_phase_type phase_ff, phase_in, fail_phase;
   logic [3:0]      word_ff, word_in;
   logic [1:0]      bidx_ff, bidx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_HUNT1;
         word_ff  <= 4'd0;
         bidx_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         word_ff  <= word_in;
         bidx_ff  <= bidx_in;
      end
   end

   // A failing byte may itself open a new frame.
   assign fail_phase = status.is_sync1 ? PH_HUNT2 : PH_HUNT1;

   // Frame parsing on each transaction, then the burst sequence.
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      word_in      = word_ff;
      bidx_in      = bidx_ff;
      req_ready    = 1'b0;
      cmd.byte_en  = 1'b0;
      cmd.phase    = phase_ff;
      cmd.rd_en    = 1'b0;
      cmd.word     = word_ff;
      cmd.byte_idx = bidx_ff;
      cmd.cap      = 1'b0;
      cmd.time1    = 1'b0;
      cmd.time2    = 1'b0;
      cmd.time3    = 1'b0;
      cmd.load_out = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.byte_en = 1'b1;
               unique case (phase_ff)
                  PH_HUNT2: phase_in = status.is_sync2 ? PH_CLASS : fail_phase;
                  PH_CLASS: phase_in = status.is_class ? PH_ID : fail_phase;
                  PH_ID: begin
                     phase_in = (status.is_id_pvt || status.is_id_velned) ? PH_LENLO
                                                                          : fail_phase;
                  end
                  PH_LENLO: phase_in = PH_LENHI;
                  PH_LENHI: begin
                     if (status.kind_pvt) begin
                        phase_in = status.len_ok ? PH_PAYLOAD : fail_phase;
                     end else begin
                        phase_in = status.len_zero ? PH_SKIPCK : PH_SKIP;
                     end
                  end
                  PH_PAYLOAD: phase_in = status.pay_last ? PH_CKA : PH_PAYLOAD;
                  PH_CKA: phase_in = PH_CKB;
                  PH_CKB: begin
                     if (status.ckb_ok) begin
                        phase_in = PH_HUNT1;
                        state_in = ST_READ;
                        word_in  = 4'd0;
                        bidx_in  = 2'd0;
                     end else begin
                        phase_in = fail_phase;
                     end
                  end
                  PH_SKIP: phase_in = status.skip_last ? PH_SKIPCK : PH_SKIP;
                  PH_SKIPCK: phase_in = status.skipck_last ? PH_HUNT1 : PH_SKIPCK;
                  default: phase_in = fail_phase;
               endcase
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            bidx_in   = bidx_ff + 2'd1;
            if (bidx_ff == 2'd3) begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: state_in = (word_ff < WORD_DATE) ? ST_EMIT : ST_CAP;
         ST_CAP: begin
            cmd.cap = 1'b1;
            if (word_ff == WORD_DATE) begin
               word_in  = WORD_CLOCK;
               state_in = ST_READ;
            end else begin
               state_in = ST_TIME1;
            end
         end
         ST_TIME1: begin
            cmd.time1 = 1'b1;
            state_in  = ST_TIME2;
         end
         ST_TIME2: begin
            cmd.time2 = 1'b1;
            state_in  = ST_TIME3;
         end
         ST_TIME3: begin
            cmd.time3 = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               if (word_ff == WORD_CLOCK) begin
                  state_in = ST_IDLE;
               end else begin
                  word_in  = word_ff + 4'd1;
                  state_in = ST_READ;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // A good checksum starts the burst.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.byte_en && phase_ff == PH_CKB && status.ckb_ok) |=>
         (state_ff == ST_READ && word_ff == 4'd0))
      else $error("burst did not start after a good frame");

   // The timestamp result closes the burst.
   assert property (@(posedge clock) disable iff (reset)
      (cmd.load_out && word_ff == WORD_CLOCK) |=> (state_ff == ST_IDLE))
      else $error("burst did not end after the timestamp");

   // No byte is taken while a burst is in progress.
   assert property (@(posedge clock) disable iff (reset)
      cmd.byte_en |-> (state_ff == ST_IDLE && !cmd.rd_en && !cmd.load_out))
      else $error("byte taken during a burst");

endmodule

`default_nettype wire

/* src/ubx_nav_pvt_frame_parser.sv */
`timescale 1ns / 1ps
`default_nettype none

// Takes one byte per cycle while parsing.
// After the second checksum byte of a good NAV-PVT frame, input stalls for the result burst:
// 15 transactions; each of the first 14 words is read from the payload RAM a byte per cycle
// and emitted as one field, and the timestamp reads two words before its conversion steps.
// Synchronous active-high reset returns to sync hunting with clear checksums and counters.
module ubx_nav_pvt_frame_parser (
   input  wire logic clock,
   input  wire logic reset,
   ubxp_req_if.sink  req_chan,
   ubxp_rsp_if.source rsp_chan
);
   import ubxp_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // Parse and burst sequencing.
   ubxp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Checksums, payload RAM, timestamp unit and output register.
   ubxp_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .rx_byte         (req_chan.rx_byte),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_field_id    (rsp_chan.field_id),
      .rsp_field_value (rsp_chan.field_value),
      .rsp_last        (rsp_chan.last)
   );

endmodule

`default_nettype wire

/* dv/ubxp_tb_ifs.sv */
`timescale 1ns / 1ps

// Expected result record kept by the checker.
package ubxp_tb_types;
   typedef struct {
      logic [3:0]         field_id;
      logic signed [32:0] field_value;
      logic               last;
   } nav_field_type;
endpackage

/* dv/ubxp_checker.sv */
`timescale 1ns / 1ps

// Watches both channels, predicts the decoded fields of every good NAV-PVT frame and compares them.
module ubxp_checker (
   input  wire logic clock,
   input  wire logic reset,
   ubxp_req_if       req_chan,
   ubxp_rsp_if       rsp_chan,
   output int        fail_count,
   output int        pending_fields
);
   import ubxp_pkg::*;
   import ubxp_tb_types::*;

   parse_phase_type phase;
   logic [15:0]     byte_cnt;
   logic [15:0]     frame_len;
   logic [1:0]      kind;
   logic [7:0]      ck_a, ck_b, rx_ck_a;
   logic [7:0]      payload [0:PvtLen-1];
   nav_field_type   field_queue [$];

   assign pending_fields = field_queue.size();

   task automatic report_mismatch(input string msg);
      $display("%0t: mismatch: %s", $realtime, msg);
      fail_count++;
   endtask

   function automatic logic [31:0] word_at(input int off);
      return {payload[off+3], payload[off+2], payload[off+1], payload[off]};
   endfunction

   function automatic logic [32:0] sext(input logic [31:0] v);
      return {v[31], v};
   endfunction

   function automatic bit leap_year(input logic [31:0] y);
      return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
   endfunction

   function automatic logic [31:0] leaps_through(input logic [31:0] y);
      return y / 4 - y / 100 + y / 400;
   endfunction

   // Unix seconds from the UTC fields of the payload.
   function automatic logic [31:0] unix_seconds();
      logic [31:0] year, month, days;
      int          mdays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      year  = {payload[5], payload[4]};
      month = payload[6];
      if (year < 2025) return 0;
      days = 365 * (year - 1970) + leaps_through(year - 1) - leaps_through(1969);
      if (month > 13) month = 13;
      for (int m = 1; m < month; m++) begin
         days += mdays[m-1];
         if (m == 2 && leap_year(year)) days += 1;
      end
      days += 32'(payload[7]) - 1;
      return days * 86400 + 32'(payload[8]) * 3600 + 32'(payload[9]) * 60 + 32'(payload[10]);
   endfunction

   // Queues the fifteen decoded fields of a good frame.
   task automatic queue_nav_fields();
      logic [32:0]   v [15];
      nav_field_type f;
      v[0] = sext(word_at(28));  v[1] = sext(word_at(24));
      v[2] = sext(word_at(64));  v[3] = sext(word_at(60));
      v[4] = sext(word_at(36));  v[5] = sext(word_at(56));
      v[6] = sext(word_at(52));  v[7] = sext(word_at(48));
      v[8] = 33'(payload[20]);   v[9] = 33'(payload[23]);
      v[10] = 33'(word_at(72));  v[11] = 33'(word_at(40));
      v[12] = 33'(word_at(68));  v[13] = 33'(word_at(44));
      v[14] = 33'(unix_seconds());
      for (int k = 0; k < 15; k++) begin
         f.field_id = 4'(k);
         f.field_value = v[k];
         f.last = (k == 14);
         field_queue.push_back(f);
      end
   endtask

   function automatic parse_phase_type resync(input logic [7:0] b);
      return (b == SYNC_FIRST) ? PH_HUNT2 : PH_HUNT1;
   endfunction

   task automatic add_sum(input logic [7:0] b);
      ck_a = ck_a + b;
      ck_b = ck_b + ck_a;
   endtask

   // Advances the parser by one byte.
   task automatic parse_byte(input logic [7:0] b);
      case (phase)
         PH_HUNT2: begin
            if (b == SYNC_SECOND) begin
               ck_a = 0; ck_b = 0; phase = PH_CLASS;
            end else phase = resync(b);
         end
         PH_CLASS: begin
            if (b == CLASS_NAV) begin
               add_sum(b); phase = PH_ID;
            end else phase = resync(b);
         end
         PH_ID: begin
            if (b == ID_PVT || b == ID_VELNED) begin
               kind = (b == ID_PVT) ? KIND_PVT : KIND_VELNED;
               add_sum(b); phase = PH_LENLO;
            end else phase = resync(b);
         end
         PH_LENLO: begin
            add_sum(b); frame_len = b; phase = PH_LENHI;
         end
         PH_LENHI: begin
            frame_len[15:8] = b;
            byte_cnt = 0;
            if (kind == KIND_PVT) begin
               if (frame_len != PvtLen) phase = resync(b);
               else begin
                  add_sum(b); phase = PH_PAYLOAD;
               end
            end else phase = (frame_len == 0) ? PH_SKIPCK : PH_SKIP;
         end
         PH_PAYLOAD: begin
            add_sum(b);
            if (byte_cnt < PvtLen) payload[byte_cnt] = b;
            byte_cnt++;
            if (byte_cnt >= PvtLen) phase = PH_CKA;
         end
         PH_CKA: begin
            rx_ck_a = b; phase = PH_CKB;
         end
         PH_CKB: begin
            if (rx_ck_a == ck_a && b == ck_b) begin
               phase = PH_HUNT1; queue_nav_fields();
            end else phase = resync(b);
         end
         PH_SKIP: begin
            byte_cnt++;
            if (byte_cnt == frame_len) begin
               byte_cnt = 0; phase = PH_SKIPCK;
            end
         end
         PH_SKIPCK: begin
            byte_cnt++;
            if (byte_cnt >= 2) phase = PH_HUNT1;
         end
         default: phase = resync(b);
      endcase
   endtask

   // Samples accepted transactions at the clock edge.
   always @(posedge clock) begin
      nav_field_type e;
      if (reset) begin
         phase = PH_HUNT1; byte_cnt = 0; frame_len = 0; kind = 0;
         ck_a = 0; ck_b = 0; rx_ck_a = 0;
         fail_count = 0;
         field_queue.delete();
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (field_queue.size() == 0)
               report_mismatch($sformatf("unexpected field id %0d", rsp_chan.field_id));
            else begin
               e = field_queue.pop_front();
               if (rsp_chan.field_id !== e.field_id)
                  report_mismatch($sformatf("field_id %0d, want %0d",
                                            rsp_chan.field_id, e.field_id));
               if (rsp_chan.field_value !== e.field_value)
                  report_mismatch($sformatf("field %0d value %h, want %h", e.field_id,
                                            rsp_chan.field_value, e.field_value));
               if (rsp_chan.last !== e.last)
                  report_mismatch($sformatf("field %0d last %b, want %b", e.field_id,
                                            rsp_chan.last, e.last));
            end
         end
         if (req_chan.valid && req_chan.ready) parse_byte(req_chan.rx_byte);
      end
   end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

// Drives framed and noisy byte streams into the parser and gives the verdict.
module tb_top;
   import ubxp_pkg::*;

   localparam int WatchdogLimit = 20000;

   logic clock = 0;
   logic reset = 1;
   int   fail_count, pending_fields;
   int   idle_cycles;
   bit   quiet;
   logic [7:0] stream [$];

   ubxp_req_if req_chan ();
   ubxp_rsp_if rsp_chan ();

   ubx_nav_pvt_frame_parser DUT (.clock(clock), .reset(reset),
                                 .req_chan(req_chan.sink), .rsp_chan(rsp_chan.source));

   ubxp_checker checker_inst (.clock(clock), .reset(reset), .req_chan(req_chan),
                              .rsp_chan(rsp_chan), .fail_count(fail_count),
                              .pending_fields(pending_fields));

   always #4 clock = ~clock;

   // Appends a NAV-PVT frame; the date fields come from the caller.
   task automatic push_pvt(input logic [15:0] year, input logic [7:0] month, input logic [7:0] day,
                           input logic [7:0] hh, input logic [7:0] mm, input logic [7:0] ss,
                           input int fill, input bit bad_ck);
      logic [7:0] body [$];
      logic [7:0] a, b;
      body = '{CLASS_NAV, ID_PVT, 8'(PvtLen), 8'h00};
      for (int i = 0; i < PvtLen; i++)
         body.push_back(fill == 0 ? 8'h00 : fill == 1 ? 8'hFF : 8'($urandom));
      body[4+4] = year[7:0]; body[4+5] = year[15:8];
      body[4+6] = month; body[4+7] = day;
      body[4+8] = hh; body[4+9] = mm; body[4+10] = ss;
      a = 0; b = 0;
      foreach (body[i]) begin
         a += body[i]; b += a;
      end
      if (bad_ck) b ^= 8'(1 << $urandom_range(0, 7));
      stream.push_back(SYNC_FIRST); stream.push_back(SYNC_SECOND);
      foreach (body[i]) stream.push_back(body[i]);
      stream.push_back(a); stream.push_back(b);
   endtask

   task automatic push_velned(input int len);
      stream.push_back(SYNC_FIRST); stream.push_back(SYNC_SECOND);
      stream.push_back(CLASS_NAV); stream.push_back(ID_VELNED);
      stream.push_back(8'(len)); stream.push_back(8'(len >> 8));
      repeat (len + 2) stream.push_back(8'($urandom));
   endtask

   // Header failures, each ending on a byte that may restart the sync.
   task automatic push_broken_header();
      stream.push_back(SYNC_FIRST);
      case ($urandom_range(0, 3))
         0: stream.push_back(SYNC_FIRST);
         1: begin
            stream.push_back(SYNC_SECOND); stream.push_back(8'($urandom));
         end
         2: begin
            stream.push_back(SYNC_SECOND); stream.push_back(CLASS_NAV);
            stream.push_back($urandom_range(0, 1) ? SYNC_FIRST : 8'($urandom));
         end
         default: begin
            stream.push_back(SYNC_SECOND); stream.push_back(CLASS_NAV);
            stream.push_back(ID_PVT); stream.push_back(8'($urandom_range(0, 1) ? 91 : 92));
            stream.push_back($urandom_range(0, 1) ? SYNC_FIRST : 8'($urandom_range(1, 255)));
         end
      endcase
   endtask

   // Sender: one byte per transaction, with random idle bursts.
   task automatic send_stream();
      while (stream.size() > 0) begin
         if (!quiet && $urandom_range(0, 5) == 0) begin
            req_chan.valid <= 0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
         req_chan.valid <= 1;
         req_chan.rx_byte <= stream.pop_front();
         do @(posedge clock); while (!req_chan.ready);
      end
      req_chan.valid <= 0;
   endtask

   // Receiver stalls in random bursts.
   initial begin
      rsp_chan.ready = 0;
      @(posedge clock);
      forever begin
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready <= 0;
            repeat ($urandom_range(1, 14)) @(posedge clock);
         end
         rsp_chan.ready <= 1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   // Watchdog on cycles without any accepted transaction.
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else if (!reset) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchdogLimit) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      idle_cycles = 0;
      quiet = 0;
      req_chan.valid = 0;
      req_chan.rx_byte = 0;
      repeat (6) @(posedge clock);
      reset <= 0;

      // Directed: early year, century year with day zero, wrapped date, checksum failure.
      push_pvt(16'd2024, 8'd12, 8'd31, 8'd23, 8'd59, 8'd59, 1, 0);
      push_pvt(16'd2100, 8'd3, 8'd0, 8'd255, 8'd255, 8'd255, 0, 0);
      push_pvt(16'hFFFF, 8'd255, 8'd255, 8'd12, 8'd0, 8'd0, 2, 0);
      push_pvt(16'd2000, 8'd2, 8'd29, 8'd0, 8'd0, 8'd0, 2, 1);
      push_velned(0);
      push_velned(3);
      push_broken_header();
      push_broken_header();
      stream.push_back(8'h00); stream.push_back(8'hFF);
      send_stream();

      // Random: short skipped frames, noise and broken headers.
      for (int i = 0; i < 6; i++) begin
         case ($urandom_range(0, 9))
            0, 1: push_velned($urandom_range(0, 10));
            2, 3, 4, 5: push_broken_header();
            default: repeat ($urandom_range(1, 6)) stream.push_back(8'($urandom));
         endcase
         if (i == 3) quiet = 1;
         send_stream();
      end

      wait (pending_fields == 0);
      repeat (200) @(posedge clock);
      if (fail_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

/* ubx_nav_pvt_frame_parser.f */
src/ubxp_pkg.sv
src/ubxp_ifs.sv
src/ubxp_dp.sv
src/ubxp_ctrl.sv
src/ubx_nav_pvt_frame_parser.sv
dv/ubxp_tb_ifs.sv
dv/ubxp_checker.sv
dv/tb_top.sv
